// ----- rtl/nrps_pkg.sv -----
// nrps_pkg: shared types and constants of the nearest reference point search
// used by nrps_front, nrps_back and the top level; no dependencies
package nrps_pkg;

    localparam int POINTS_DEF     = 1024;
    localparam int COORD_BITS_DEF = 24;

    // fixed field widths
    localparam int INDEX_W     = 10;
    localparam int COUNT_W     = 11;
    localparam int DIST_W      = 25;
    localparam int COUNT_RESET = 1024;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // result tdata: nearest_index, min_distance, padded to bytes
    localparam int M_TDATA_W = ((INDEX_W + DIST_W + 7) / 8) * 8;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // mode field encoding
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_QUERY = 1'b1
    } t_kind;

    typedef struct packed {
        logic  valid;
        t_kind kind;
    } t_cmd_ctl;

endpackage

// ----- rtl/nrps_ram.sv -----
// nrps_ram: generic single write port, single read port ram with registered read
// no dependencies
module nrps_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/nrps_front.sv -----
// nrps_front: input stream acceptance, item classification and command queue
// depends on nrps_pkg
module nrps_front #(
    parameter int POINTS     = nrps_pkg::POINTS_DEF,
    parameter int COORD_BITS = nrps_pkg::COORD_BITS_DEF,
    localparam int IW        = nrps_pkg::INDEX_W,
    localparam int TDATA_W   = ((IW + 2 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [TDATA_W-1:0]    i_s_axis_tdata,
    input  logic [0:0]            i_s_axis_tuser,
    output nrps_pkg::t_cmd_ctl    o_cmd,
    input  logic                  i_cmd_ready,
    output logic [IW-1:0]         o_cmd_index,
    output logic [COORD_BITS-1:0] o_cmd_x,
    output logic [COORD_BITS-1:0] o_cmd_y
);

    localparam int DEPTH = nrps_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = ($clog2(POINTS + 1) > IW) ? $clog2(POINTS + 1) : IW;

    nrps_pkg::t_kind       r_kind [DEPTH];
    logic [IW-1:0]         r_index [DEPTH];
    logic [COORD_BITS-1:0] r_x [DEPTH];
    logic [COORD_BITS-1:0] r_y [DEPTH];
    logic [PW-1:0]         r_wr_ptr;
    logic [PW-1:0]         r_rd_ptr;
    logic [CNT_W-1:0]      r_count;

    nrps_pkg::t_kind in_kind;
    logic [IW-1:0]   in_index;
    logic            in_keep;
    logic            push;
    logic            pop;

    // classify: writes past the table are dropped here
    assign in_index = i_s_axis_tdata[IW-1:0];
    assign in_kind  = (i_s_axis_tuser[0] == nrps_pkg::MODE_QUERY) ?
                      nrps_pkg::KIND_QUERY : nrps_pkg::KIND_WRITE;
    assign in_keep  = (in_kind == nrps_pkg::KIND_QUERY) ||
                      (CMP_W'(in_index) < CMP_W'(POINTS));

    assign o_s_axis_tready = (r_count != CNT_W'(DEPTH));
    assign push = i_s_axis_tvalid && o_s_axis_tready && in_keep;
    assign pop  = o_cmd.valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_kind[r_wr_ptr]  <= in_kind;
                r_index[r_wr_ptr] <= in_index;
                r_x[r_wr_ptr]     <= i_s_axis_tdata[IW +: COORD_BITS];
                r_y[r_wr_ptr]     <= i_s_axis_tdata[IW + COORD_BITS +: COORD_BITS];
                r_wr_ptr          <= PW'(r_wr_ptr + 1'b1);
            end
            if (pop) begin
                r_rd_ptr <= PW'(r_rd_ptr + 1'b1);
            end
            if (push && !pop) begin
                r_count <= CNT_W'(r_count + 1'b1);
            end else if (pop && !push) begin
                r_count <= CNT_W'(r_count - 1'b1);
            end
        end
    end

    assign o_cmd.valid = (r_count != '0);
    assign o_cmd.kind  = r_kind[r_rd_ptr];
    assign o_cmd_index = r_index[r_rd_ptr];
    assign o_cmd_x     = r_x[r_rd_ptr];
    assign o_cmd_y     = r_y[r_rd_ptr];

endmodule

// ----- rtl/nrps_back.sv -----
// nrps_back: executes table writes and nearest point scans, holds the result register
// depends on nrps_pkg and nrps_ram
module nrps_back #(
    parameter int POINTS     = nrps_pkg::POINTS_DEF,
    parameter int COORD_BITS = nrps_pkg::COORD_BITS_DEF,
    localparam int IW        = nrps_pkg::INDEX_W,
    localparam int DW        = nrps_pkg::DIST_W,
    localparam int AW        = (POINTS > 1) ? $clog2(POINTS) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  nrps_pkg::t_cmd_ctl    i_cmd,
    output logic                  o_cmd_ready,
    input  logic [IW-1:0]         i_cmd_index,
    input  logic [COORD_BITS-1:0] i_cmd_x,
    input  logic [COORD_BITS-1:0] i_cmd_y,
    input  logic [AW-1:0]         i_last_idx,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output logic [IW-1:0]         o_res_index,
    output logic [DW-1:0]         o_res_dist
);

    localparam int CB    = COORD_BITS;
    localparam int SUM_W = CB + 2;
    localparam int SAT_W = (SUM_W > DW) ? SUM_W : DW;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_PUT
    } t_state;

    t_state           r_state;
    logic [AW-1:0]    r_scan_idx;
    logic [CB-1:0]    r_qx;
    logic [CB-1:0]    r_qy;
    logic [SUM_W-1:0] r_best_d;
    logic [AW-1:0]    r_best_i;
    logic             r_out_valid;
    logic [IW-1:0]    r_out_index;
    logic [DW-1:0]    r_out_dist;

    // scan pipeline: p1 ram data, p2 absolute differences, p3 distance
    logic             r_p1_valid, r_p2_valid, r_p3_valid;
    logic             r_p1_last, r_p2_last, r_p3_last;
    logic             r_p1_first, r_p2_first, r_p3_first;
    logic [AW-1:0]    r_p1_idx, r_p2_idx, r_p3_idx;
    logic [CB:0]      r_p2_dx, r_p2_dy;
    logic [SUM_W-1:0] r_p3_sum;

    logic             ram_we;
    logic             ram_re;
    logic [2*CB-1:0]  ram_rdata;
    logic [CB-1:0]    ref_x, ref_y;
    logic [CB:0]      diff_x, diff_y;
    logic [CB:0]      n_dx, n_dy;
    logic             take_best;
    logic             load_out;
    logic [SAT_W-1:0] best_ext;
    logic [DW-1:0]    dist_sat;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign ram_we = (r_state == S_IDLE) && i_cmd.valid && (i_cmd.kind == nrps_pkg::KIND_WRITE);
    assign ram_re = (r_state == S_SCAN);

    nrps_ram #(
        .WIDTH (2 * CB),
        .DEPTH (POINTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_cmd_index)),
        .i_wdata ({i_cmd_y, i_cmd_x}),
        .i_re    (ram_re),
        .i_raddr (r_scan_idx),
        .o_rdata (ram_rdata)
    );

    assign ref_x  = ram_rdata[CB-1:0];
    assign ref_y  = ram_rdata[2*CB-1:CB];
    assign diff_x = {r_qx[CB-1], r_qx} - {ref_x[CB-1], ref_x};
    assign diff_y = {r_qy[CB-1], r_qy} - {ref_y[CB-1], ref_y};
    assign n_dx   = diff_x[CB] ? ((CB+1)'(0) - diff_x) : diff_x;
    assign n_dy   = diff_y[CB] ? ((CB+1)'(0) - diff_y) : diff_y;

    // later index wins on equal distance
    assign take_best = r_p3_valid && (r_p3_first || (r_p3_sum <= r_best_d));
    assign load_out  = (r_state == S_PUT) && (!r_out_valid || i_res_ready);

    assign best_ext = SAT_W'(r_best_d);
    assign dist_sat = (best_ext > SAT_W'(nrps_pkg::DIST_MAX)) ?
                      nrps_pkg::DIST_MAX : best_ext[DW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
        end else begin
            r_p1_valid <= ram_re;
            r_p2_valid <= r_p1_valid;
            r_p3_valid <= r_p2_valid;
        end
        r_p1_idx   <= r_scan_idx;
        r_p1_last  <= (r_scan_idx == i_last_idx);
        r_p1_first <= (r_scan_idx == '0);
        r_p2_idx   <= r_p1_idx;
        r_p2_last  <= r_p1_last;
        r_p2_first <= r_p1_first;
        r_p2_dx    <= n_dx;
        r_p2_dy    <= n_dy;
        r_p3_idx   <= r_p2_idx;
        r_p3_last  <= r_p2_last;
        r_p3_first <= r_p2_first;
        r_p3_sum   <= SUM_W'(r_p2_dx) + SUM_W'(r_p2_dy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_scan_idx  <= '0;
        end else begin
            if (r_out_valid && i_res_ready) begin
                r_out_valid <= 1'b0;
            end
            if (take_best) begin
                r_best_d <= r_p3_sum;
                r_best_i <= r_p3_idx;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid && (i_cmd.kind == nrps_pkg::KIND_QUERY)) begin
                        r_qx       <= i_cmd_x;
                        r_qy       <= i_cmd_y;
                        r_scan_idx <= '0;
                        r_state    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_scan_idx == i_last_idx) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_scan_idx <= AW'(r_scan_idx + 1'b1);
                    end
                end
                S_DRAIN: begin
                    if (r_p3_valid && r_p3_last) begin
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (load_out) begin
                        r_out_valid <= 1'b1;
                        r_out_index <= IW'(r_best_i);
                        r_out_dist  <= dist_sat;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res_index = r_out_index;
    assign o_res_dist  = r_out_dist;

    // scan results only arrive while a query is in flight
    a_pipe_in_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p3_valid |-> (r_state == S_SCAN || r_state == S_DRAIN))
        else $error("scan result outside a query");

    // the final entry reaches the compare stage only after issue has ended
    a_last_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p3_valid && r_p3_last) |-> (r_state == S_DRAIN))
        else $error("last scan entry arrived outside drain");

    // scan address stays within the searched range
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_scan_idx <= i_last_idx))
        else $error("scan address beyond point count");

    // a finished query points at a searched entry
    a_best_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT) |-> (r_best_i <= i_last_idx))
        else $error("nearest index beyond point count");

endmodule

// ----- rtl/nearest_reference_point_search.sv -----
// nearest_reference_point_search: top level, configuration register and stream ports
// depends on nrps_pkg, nrps_front, nrps_back (and nrps_ram through nrps_back)
//
// usage
//   input stream s_axis: tuser[0] is the mode. mode 0 writes one reference point
//   (point_index, x, y) into the table, mode 1 queries the coordinate (x, y).
//   output stream m_axis: one transaction per query carrying the index of the
//   reference point at least manhattan distance (later index on ties) and the
//   distance. writes produce no output; writes past the table are dropped.
//   i_cfg_we/i_cfg_wdata set point_count (entries searched, clamped to 1..POINTS);
//   write it only while the block is idle.
// write and query handling
//   a write is taken by the back end only while it is idle. during a query the scan
//   reads one table entry per cycle from the single ram read port, then drains the
//   scan pipeline (ram data, differences, distance) into the result register.
//   a four entry queue lets the input keep accepting while a scan runs.
// reset
//   synchronous active low; the queue and result register empty, point_count
//   returns to 1024 (clamped to POINTS). table contents are undefined until written.
// stall
//   a finished result waits in the output register; the back end still runs the next
//   scan, then holds it until that register frees up. the input stalls once the queue is full.
module nearest_reference_point_search #(
    parameter int POINTS     = nrps_pkg::POINTS_DEF,
    parameter int COORD_BITS = nrps_pkg::COORD_BITS_DEF,
    localparam int S_TDATA_W = ((nrps_pkg::INDEX_W + 2 * COORD_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W = nrps_pkg::M_TDATA_W,
    localparam int CFG_W     = nrps_pkg::COUNT_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration: point_count
    input  logic                 i_cfg_we,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    // input transactions
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,   // point_index, x_coord, y_coord, zero pad
    input  logic [0:0]           i_s_axis_tuser,   // mode
    // result transactions
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0] o_m_axis_tdata    // nearest_index, min_distance, zero pad
);

    localparam int IW    = nrps_pkg::INDEX_W;
    localparam int DW    = nrps_pkg::DIST_W;
    localparam int AW    = (POINTS > 1) ? $clog2(POINTS) : 1;
    localparam int CMP_W = ($clog2(POINTS + 1) > CFG_W) ? $clog2(POINTS + 1) : CFG_W;
    localparam int RESET_LAST =
        ((nrps_pkg::COUNT_RESET > POINTS) ? POINTS : nrps_pkg::COUNT_RESET) - 1;

    // point_count is kept as the clamped index of the last entry to search
    logic [AW-1:0]    r_last_idx;
    logic [AW-1:0]    n_last_idx;
    logic [CMP_W-1:0] cfg_ext;

    nrps_pkg::t_cmd_ctl    cmd;
    logic                  cmd_ready;
    logic [IW-1:0]         cmd_index;
    logic [COORD_BITS-1:0] cmd_x;
    logic [COORD_BITS-1:0] cmd_y;
    logic [IW-1:0]         res_index;
    logic [DW-1:0]         res_dist;

    assign cfg_ext = CMP_W'(i_cfg_wdata);

    always_comb begin
        if (cfg_ext == '0) begin
            n_last_idx = '0;                      // zero count searches entry 0
        end else if (cfg_ext > CMP_W'(POINTS)) begin
            n_last_idx = AW'(POINTS - 1);         // count beyond the table
        end else begin
            n_last_idx = AW'(cfg_ext - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_idx <= AW'(RESET_LAST);
        end else if (i_cfg_we) begin
            r_last_idx <= n_last_idx;
        end
    end

    // front end: accept and classify transactions, queue commands
    nrps_front #(
        .POINTS     (POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_cmd           (cmd),
        .i_cmd_ready     (cmd_ready),
        .o_cmd_index     (cmd_index),
        .o_cmd_x         (cmd_x),
        .o_cmd_y         (cmd_y)
    );

    // back end: table writes, scan pipeline and result register
    nrps_back #(
        .POINTS     (POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_cmd_ready (cmd_ready),
        .i_cmd_index (cmd_index),
        .i_cmd_x     (cmd_x),
        .i_cmd_y     (cmd_y),
        .i_last_idx  (r_last_idx),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .o_res_index (res_index),
        .o_res_dist  (res_dist)
    );

    assign o_m_axis_tdata = {{(M_TDATA_W - IW - DW){1'b0}}, res_dist, res_index};

endmodule
